// ===== rtl/core/gisf_pkg.sv =====
package gisf_pkg;

  parameter int unsigned MaxVerticesDef = 64;

  localparam int unsigned ModeW = 2;
  localparam int unsigned IdW   = 6;
  localparam int unsigned DegW  = 12;

  typedef enum logic [ModeW-1:0] {
    MODE_EDGE    = 2'd0,
    MODE_VERTEX  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RD_A    = 2'd0,
    RD_B    = 2'd1,
    RD_IDX  = 2'd2,
    RD_BEST = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_b;
    logic    scan_init;
    logic    scan_step;
    logic    pick_apply;
    logic    emit_init;
    logic    emit_step;
  } gisf_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic compute;
    logic idx_end;
    logic cand_any;
    logic found;
    logic emit_left;
  } gisf_status_t;

endpackage

// ===== rtl/core/gisf_item_if.sv =====
interface gisf_item_if;
  logic                       valid;
  logic                       ready;
  logic [gisf_pkg::ModeW-1:0] mode;
  logic [gisf_pkg::IdW-1:0]   vertex_a;
  logic [gisf_pkg::IdW-1:0]   vertex_b;

  modport source (output valid, mode, vertex_a, vertex_b, input ready);
  modport sink   (input valid, mode, vertex_a, vertex_b, output ready);
endinterface

// ===== rtl/core/gisf_result_if.sv =====
interface gisf_result_if;
  logic                     valid;
  logic                     ready;
  logic [gisf_pkg::IdW-1:0] vertex_id;
  logic                     in_independent_set;
  logic                     last_vertex;

  modport source (output valid, vertex_id, in_independent_set, last_vertex, input ready);
  modport sink   (input valid, vertex_id, in_independent_set, last_vertex, output ready);
endinterface

// ===== rtl/core/greedy_independent_set_finder.sv =====
// Greedy minimum-degree independent set over a graph of up to MaxVertices vertices, with
// adjacency rows and degree counts in one single-port-read RAM and presence, removal and
// choice marks in flip-flops. An isolated-vertex item is only accepted; an edge item is
// accepted, then each endpoint's row gets a read-modify-write through the RAM port.
// A compute item is accepted and then runs picks until a final candidate check finds no
// candidate, each pick being a candidate check, a full degree scan at one RAM read per
// cycle with a closing step, a read of the winner's row and the removal update.
// Reporting then walks the vertex indices up to the highest present vertex and closes,
// holding while the result side stalls. Reset clears everything at once through row
// valid bits; there is no clearing pass. Results wait in an output register while the
// next item is taken.
module greedy_independent_set_finder #(
  parameter int unsigned MaxVertices = gisf_pkg::MaxVerticesDef
) (
  input logic           clk_i,
  input logic           rst_ni,
  gisf_item_if.sink     item_i,
  gisf_result_if.source result_o
);
  import gisf_pkg::*;

  gisf_cmd_t    cmd;
  gisf_status_t st;
  logic         in_ready;

  gisf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gisf_datapath #(
    .MaxVertices (MaxVertices)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (item_i.mode),
    .vertex_a_i      (item_i.vertex_a),
    .vertex_b_i      (item_i.vertex_b),
    .cmd_i           (cmd),
    .st_o            (st),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .out_vertex_id_o (result_o.vertex_id),
    .out_in_set_o    (result_o.in_independent_set),
    .out_last_o      (result_o.last_vertex)
  );

  assign item_i.ready = in_ready;

  a_scan_finds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_step && st.idx_end |=> st.found)
    else $error("degree scan ended without a candidate");

  a_write_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> $past(cmd.rd_en))
    else $error("row write without a preceding row read");

  a_no_accept_while_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !st.emit_left)
    else $error("beat accepted while reporting is in progress");

endmodule

// ===== rtl/core/gisf_ram.sv =====
module gisf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gisf_ctrl.sv =====
module gisf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gisf_pkg::gisf_status_t st_i,
  output gisf_pkg::gisf_cmd_t    cmd_o
);
  import gisf_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_RD_A     = 9'b000000010,
    ST_WR_A     = 9'b000000100,
    ST_RD_B     = 9'b000001000,
    ST_WR_B     = 9'b000010000,
    ST_CHECK    = 9'b000100000,
    ST_SCAN     = 9'b001000000,
    ST_PICK_RD  = 9'b010000000,
    ST_PICK_UPD = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_A;
    in_ready_o = (state_q == ST_IDLE) && !emit_q;
    if (emit_q) begin
      if (st_i.emit_left) begin
        cmd_o.emit_step = 1'b1;
      end else begin
        emit_d = 1'b0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            if (st_i.edge_ok) begin
              state_d = ST_RD_A;
            end else if (st_i.compute) begin
              state_d = ST_CHECK;
            end
          end
        end
        ST_RD_A: begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_A;
          state_d      = ST_WR_A;
        end
        ST_WR_A: begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_RD_B;
        end
        ST_RD_B: begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_B;
          state_d      = ST_WR_B;
        end
        ST_WR_B: begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_b  = 1'b1;
          state_d     = ST_IDLE;
        end
        ST_CHECK: begin
          if (st_i.cand_any) begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end else begin
            cmd_o.emit_init = 1'b1;
            emit_d          = 1'b1;
            state_d         = ST_IDLE;
          end
        end
        ST_SCAN: begin
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_IDX;
          cmd_o.scan_step = 1'b1;
          if (st_i.idx_end) begin
            state_d = ST_PICK_RD;
          end
        end
        ST_PICK_RD: begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_BEST;
          state_d      = ST_PICK_UPD;
        end
        ST_PICK_UPD: begin
          cmd_o.pick_apply = 1'b1;
          state_d          = ST_CHECK;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule

// ===== rtl/core/gisf_datapath.sv =====
module gisf_datapath #(
  parameter int unsigned MaxVertices = gisf_pkg::MaxVerticesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gisf_pkg::ModeW-1:0] mode_i,
  input  logic [gisf_pkg::IdW-1:0]   vertex_a_i,
  input  logic [gisf_pkg::IdW-1:0]   vertex_b_i,
  input  gisf_pkg::gisf_cmd_t        cmd_i,
  output gisf_pkg::gisf_status_t     st_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gisf_pkg::IdW-1:0]   out_vertex_id_o,
  output logic                       out_in_set_o,
  output logic                       out_last_o
);
  import gisf_pkg::*;

  localparam int unsigned AW   = $clog2(MaxVertices);
  localparam int unsigned IW   = $clog2(MaxVertices + 1);
  localparam int unsigned RowW = DegW + MaxVertices;
  localparam logic [DegW-1:0] DegMax = '1;

  function automatic logic [MaxVertices-1:0] onehot(input logic [AW-1:0] pos);
    logic [MaxVertices-1:0] v;
    v      = '0;
    v[pos] = 1'b1;
    return v;
  endfunction

  logic [AW-1:0]          a_q, b_q, best_q, ev_idx_q;
  logic [IW-1:0]          idx_q, idx_d;
  logic [DegW-1:0]        best_deg_q;
  logic                   found_q, ev_q, rvld_q;
  logic [MaxVertices-1:0] present_q, row_valid_q, removed_q, chosen_q, emit_q;
  logic                   out_valid_q, out_in_set_q, out_last_q;
  logic [IdW-1:0]         out_id_q;

  logic                   a_ok, b_ok, edge_ok, vertex_ok, compute;
  logic [AW-1:0]          raddr, waddr, wother, idx_addr;
  logic                   ram_re;
  logic [RowW-1:0]        rdata, row_cur, wdata;
  logic [DegW-1:0]        cur_deg, deg_inc;
  logic [MaxVertices-1:0] cur_adj, idx_bit, emit_rest;
  logic                   idx_end, out_free, emit_hit, emit_load, cand_ev, better;

  assign a_ok      = 32'(vertex_a_i) < MaxVertices;
  assign b_ok      = 32'(vertex_b_i) < MaxVertices;
  assign edge_ok   = (mode_i == MODE_EDGE) && a_ok && b_ok;
  assign vertex_ok = (mode_i == MODE_VERTEX) && a_ok;
  assign compute   = (mode_i == MODE_COMPUTE);

  assign idx_addr = idx_q[AW-1:0];
  assign idx_end  = (idx_q == IW'(MaxVertices));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_A:    raddr = a_q;
      RD_B:    raddr = b_q;
      RD_IDX:  raddr = idx_addr;
      default: raddr = best_q;
    endcase
  end

  assign ram_re = cmd_i.rd_en && !((cmd_i.rd_sel == RD_IDX) && idx_end);
  assign waddr  = cmd_i.wr_b ? b_q : a_q;
  assign wother = cmd_i.wr_b ? a_q : b_q;

  assign row_cur = rvld_q ? rdata : '0;
  assign cur_deg = row_cur[RowW-1 -: DegW];
  assign cur_adj = row_cur[MaxVertices-1:0];
  assign deg_inc = (cur_deg == DegMax) ? cur_deg : cur_deg + DegW'(1);
  assign wdata   = {deg_inc, cur_adj | onehot(wother)};

  gisf_ram #(
    .Width (RowW),
    .Depth (MaxVertices)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cand_ev = ev_q && present_q[ev_idx_q] && !removed_q[ev_idx_q];
  assign better  = !found_q || (cur_deg < best_deg_q);

  assign idx_bit   = onehot(idx_addr);
  assign emit_rest = emit_q & ~idx_bit;
  assign emit_hit  = emit_q[idx_addr];
  assign emit_load = cmd_i.emit_step && emit_hit && out_free;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_init || cmd_i.emit_init) begin
      idx_d = '0;
    end else if (cmd_i.scan_step && !idx_end) begin
      idx_d = idx_q + IW'(1);
    end else if (cmd_i.emit_step && (!emit_hit || out_free)) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      row_valid_q <= '0;
      removed_q   <= '0;
      chosen_q    <= '0;
      emit_q      <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      ev_q        <= 1'b0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ev_q  <= cmd_i.scan_step && !idx_end;
      if (ram_re) begin
        rvld_q <= row_valid_q[raddr];
      end
      if (cmd_i.accept) begin
        if (edge_ok) begin
          present_q <= present_q | onehot(AW'(vertex_a_i)) | onehot(AW'(vertex_b_i));
        end else if (vertex_ok) begin
          present_q <= present_q | onehot(AW'(vertex_a_i));
        end else if (compute) begin
          removed_q <= '0;
          chosen_q  <= '0;
        end
      end
      if (cmd_i.wr_en) begin
        row_valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (cand_ev && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.pick_apply) begin
        removed_q        <= removed_q | cur_adj | onehot(best_q);
        chosen_q[best_q] <= 1'b1;
      end
      if (cmd_i.emit_init) begin
        emit_q <= present_q;
      end else if (emit_load) begin
        emit_q <= emit_rest;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q <= idx_addr;
    if (cmd_i.accept) begin
      a_q <= AW'(vertex_a_i);
      b_q <= AW'(vertex_b_i);
    end
    if (cand_ev && better) begin
      best_q     <= ev_idx_q;
      best_deg_q <= cur_deg;
    end
    if (emit_load) begin
      out_id_q     <= IdW'(idx_addr);
      out_in_set_q <= chosen_q[idx_addr];
      out_last_q   <= ~|emit_rest;
    end
  end

  assign st_o.edge_ok   = edge_ok;
  assign st_o.compute   = compute;
  assign st_o.idx_end   = idx_end;
  assign st_o.cand_any  = |(present_q & ~removed_q);
  assign st_o.found     = found_q;
  assign st_o.emit_left = |emit_q;

  assign out_valid_o     = out_valid_q;
  assign out_vertex_id_o = out_id_q;
  assign out_in_set_o    = out_in_set_q;
  assign out_last_o      = out_last_q;

endmodule

// ===== sim/greedy_set_checker.sv =====
module greedy_set_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  gisf_item_if        item_i,
  gisf_result_if      result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gisf_pkg::*;

  localparam int unsigned NumVertices = MaxVerticesDef;
  localparam int unsigned DegreeMax   = (1 << DegW) - 1;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [IdW-1:0] vertex_id;
    logic           in_set;
    logic           last;
  } vertex_report_t;

  vertex_report_t           report_q[$];
  logic [NumVertices-1:0]   present;
  logic [NumVertices-1:0]   adj_row [NumVertices];
  logic [DegW-1:0]          degree  [NumVertices];
  int unsigned              mismatch_count;
  int unsigned              pending_count;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic logic [DegW-1:0] bump(logic [DegW-1:0] deg);
    int unsigned sum;
    sum = deg + 1;
    return (sum > DegreeMax) ? DegW'(DegreeMax) : DegW'(sum);
  endfunction

  task automatic add_edge(input logic [IdW-1:0] a, input logic [IdW-1:0] b);
    present[a]    = 1'b1;
    present[b]    = 1'b1;
    adj_row[a][b] = 1'b1;
    adj_row[b][a] = 1'b1;
    degree[a]     = bump(degree[a]);
    degree[b]     = bump(degree[b]);
  endtask

  // Pick min-degree survivors (lowest index on ties), drop their neighbors, then queue one report per present vertex.
  task automatic queue_cover_split();
    logic [NumVertices-1:0] removed;
    logic [NumVertices-1:0] chosen;
    logic                   found;
    int unsigned            best;
    logic [DegW-1:0]        best_deg;
    int unsigned            last_idx;
    vertex_report_t         rep;
    removed = ~present;
    chosen  = '0;
    do begin
      found    = 1'b0;
      best     = 0;
      best_deg = '0;
      for (int unsigned i = 0; i < NumVertices; i++) begin
        if (!removed[i] && (!found || degree[i] < best_deg)) begin
          found    = 1'b1;
          best     = i;
          best_deg = degree[i];
        end
      end
      if (found) begin
        chosen[best]  = 1'b1;
        removed       = removed | adj_row[best];
        removed[best] = 1'b1;
      end
    end while (found);
    last_idx = 0;
    for (int unsigned i = 0; i < NumVertices; i++) begin
      if (present[i]) last_idx = i;
    end
    for (int unsigned i = 0; i < NumVertices; i++) begin
      if (present[i]) begin
        rep.vertex_id = IdW'(i);
        rep.in_set    = chosen[i];
        rep.last      = (i == last_idx);
        report_q      = {report_q, rep};
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_report_t want;
    if (!rst_ni) begin
      report_q.delete();
      present        = '0;
      mismatch_count = 0;
      pending_count  = 0;
      for (int unsigned i = 0; i < NumVertices; i++) begin
        adj_row[i] = '0;
        degree[i]  = '0;
      end
    end else begin
      if (item_i.valid && item_i.ready) begin
        case (item_i.mode)
          MODE_EDGE: begin
            add_edge(item_i.vertex_a, item_i.vertex_b);
          end
          MODE_VERTEX: begin
            present[item_i.vertex_a] = 1'b1;
          end
          MODE_COMPUTE: begin
            queue_cover_split();
          end
          default: begin
          end
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        if (report_q.size() == 0) begin
          if (mismatch_count < ReportLimit) begin
            $display("%0t: unexpected beat: vertex %0d set %b last %b", $realtime,
                     result_i.vertex_id, result_i.in_independent_set, result_i.last_vertex);
          end
          mismatch_count++;
        end else begin
          want = report_q.pop_front();
          if (result_i.vertex_id !== want.vertex_id ||
              result_i.in_independent_set !== want.in_set ||
              result_i.last_vertex !== want.last) begin
            if (mismatch_count < ReportLimit) begin
              $display("%0t: beat vertex %0d set %b last %b, expected vertex %0d set %b last %b",
                       $realtime, result_i.vertex_id, result_i.in_independent_set,
                       result_i.last_vertex, want.vertex_id, want.in_set, want.last);
            end
            mismatch_count++;
          end
        end
      end
      pending_count = report_q.size();
    end
  end

endmodule

// ===== sim/greedy_independent_set_finder_test.sv =====
module greedy_independent_set_finder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gisf_pkg::*;

  localparam logic [ModeW-1:0] ModeUnused   = 2'd3;
  localparam int unsigned      RandomItems  = 175;
  localparam int unsigned      SettleCycles = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        tx_quiet;
  logic        rx_quiet;
  int unsigned fail_count;
  int unsigned pending;

  gisf_item_if   item_ch ();
  gisf_result_if result_ch ();

  greedy_independent_set_finder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  greedy_set_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_ch),
    .result_i     (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IdW-1:0] pick_vertex();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return IdW'($urandom_range(0, 15));
    if (roll < 65) return IdW'($urandom_range(48, 63));
    return IdW'($urandom_range(0, 63));
  endfunction

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [IdW-1:0] a,
                           input logic [IdW-1:0] b);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid    <= 1'b1;
    item_ch.mode     <= mode;
    item_ch.vertex_a <= a;
    item_ch.vertex_b <= b;
    do @(negedge clk_i); while (!item_ch.ready);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    rx_quiet        = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if ($urandom_range(0, 9) == 0) rx_quiet = !rx_quiet;
      stall = pick_gap(rx_quiet);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned batch_len;
    int unsigned roll;
    tx_quiet         = 1'b0;
    rst_ni           <= 1'b0;
    item_ch.valid    <= 1'b0;
    item_ch.mode     <= MODE_EDGE;
    item_ch.vertex_a <= '0;
    item_ch.vertex_b <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(MODE_COMPUTE, '0, '0);
    send_item(ModeUnused, 6'd63, 6'd63);
    send_item(MODE_VERTEX, 6'd63, 6'd0);
    send_item(MODE_VERTEX, 6'd0, 6'd63);
    send_item(MODE_COMPUTE, 6'd63, 6'd63);
    drain_results();
    send_item(MODE_EDGE, 6'd0, 6'd63);
    send_item(MODE_EDGE, 6'd0, 6'd63);
    send_item(MODE_EDGE, 6'd5, 6'd5);
    send_item(MODE_EDGE, 6'd63, 6'd1);
    send_item(MODE_EDGE, 6'd2, 6'd1);
    send_item(MODE_EDGE, 6'd2, 6'd3);
    send_item(MODE_VERTEX, 6'd63, 6'd42);
    send_item(MODE_COMPUTE, '0, '0);
    send_item(MODE_COMPUTE, '0, '0);
    drain_results();
    send_item(MODE_EDGE, 6'd10, 6'd11);
    send_item(MODE_EDGE, 6'd11, 6'd12);
    send_item(MODE_EDGE, 6'd12, 6'd10);
    send_item(MODE_EDGE, 6'd12, 6'd13);
    send_item(MODE_COMPUTE, '0, '0);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      batch_len = $urandom_range(2, 12);
      if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
      repeat (batch_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          send_item(MODE_EDGE, pick_vertex(), pick_vertex());
          items_sent++;
        end else if (roll < 92) begin
          send_item(MODE_VERTEX, pick_vertex(), IdW'($urandom));
          items_sent++;
        end else begin
          send_item(ModeUnused, IdW'($urandom), IdW'($urandom));
        end
      end
      if ($urandom_range(0, 6) != 0) begin
        send_item(MODE_COMPUTE, IdW'($urandom), IdW'($urandom));
        items_sent++;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    send_item(MODE_COMPUTE, IdW'($urandom), IdW'($urandom));

    item_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
